/* sv/assert_macros.svh */
// Assertion helpers included by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sidec_pkg.sv */
// ----------------------------------------------------------------------------
// sidec_pkg
// Widths and character codes for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sidec_pkg;

    // Width of the integer that is converted (8 to 32 with a 32-bit port).
    localparam int INT_WIDTH  = 32;
    localparam int NUM_WIDTH  = 32;
    localparam int CHAR_W     = 6;

    // Decimal digits needed for INT_WIDTH bits: floor(INT_WIDTH * log10(2)) + 1.
    localparam int NUM_DIGITS = (INT_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W      = 4 * NUM_DIGITS;

    localparam int CONV_CNT_W = $clog2(INT_WIDTH);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

endpackage

/* sv/signed_int_to_decimal_ascii.sv */
// Sequence: after start is taken, the 32-step shift-and-add-3 loop converts the magnitude
// and a scan drops the leading zeros; a negative number then gets a minus sign first, and
// characters follow on consecutive cycles, one character a cycle, last flag on the last.
// busy stays high from the taken start until the last character is on the output.
// The receiver cannot stall; results are never held back.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and drops the strobe.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer into its decimal ASCII text, most significant first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_int_to_decimal_ascii
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [sidec_pkg::NUM_WIDTH-1:0] number,
    output logic                              strobe,
    output logic [sidec_pkg::CHAR_W-1:0]      ascii_char,
    output logic                              last_char
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CONVERT,
        ST_TRIM,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t                                state_reg, state_next;
    logic [sidec_pkg::INT_WIDTH-1:0]       mag_reg, mag_next;
    logic [sidec_pkg::BCD_W-1:0]           bcd_reg, bcd_next;
    logic                                  neg_reg, neg_next;
    logic [sidec_pkg::CONV_CNT_W-1:0]      conv_cnt_reg, conv_cnt_next;
    logic [sidec_pkg::DIG_CNT_W-1:0]       dig_cnt_reg, dig_cnt_next;
    logic                                  strobe_reg, strobe_next;
    logic [sidec_pkg::CHAR_W-1:0]          char_reg, char_next;
    logic                                  last_reg, last_next;

    logic [sidec_pkg::INT_WIDTH-1:0]       in_value;
    logic [sidec_pkg::BCD_W-1:0]           bcd_adj;
    logic [3:0]                            top_digit;

    assign in_value  = number[sidec_pkg::INT_WIDTH-1:0];
    assign top_digit = bcd_reg[sidec_pkg::BCD_W-1 -: 4];

    // Add 3 to every BCD digit of 5 or more before the shift.
    always_comb
    begin
        for (int i = 0; i < sidec_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        bcd_next      = bcd_reg;
        neg_next      = neg_reg;
        conv_cnt_next = conv_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        strobe_next   = 1'b0;
        char_next     = char_reg;
        last_next     = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    neg_next      = in_value[sidec_pkg::INT_WIDTH-1];
                    // The unsigned magnitude is exact also for the most negative value.
                    mag_next      = in_value[sidec_pkg::INT_WIDTH-1] ? (~in_value + 1'b1)
                                                                     : in_value;
                    bcd_next      = '0;
                    conv_cnt_next = sidec_pkg::CONV_CNT_W'(sidec_pkg::INT_WIDTH - 1);
                    state_next    = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                bcd_next = {bcd_adj[sidec_pkg::BCD_W-2:0], mag_reg[sidec_pkg::INT_WIDTH-1]};
                mag_next = {mag_reg[sidec_pkg::INT_WIDTH-2:0], 1'b0};
                conv_cnt_next = conv_cnt_reg - 1'b1;
                if (conv_cnt_reg == '0)
                begin
                    dig_cnt_next = sidec_pkg::DIG_CNT_W'(sidec_pkg::NUM_DIGITS);
                    state_next   = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                // Drop leading zeros, but always keep the units digit.
                if (top_digit == 4'd0 && dig_cnt_reg != sidec_pkg::DIG_CNT_W'(1))
                begin
                    bcd_next     = {bcd_reg[sidec_pkg::BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else if (neg_reg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = sidec_pkg::CHAR_MINUS;
                last_next   = 1'b0;
                state_next  = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                strobe_next  = 1'b1;
                char_next    = sidec_pkg::CHAR_ZERO + {2'b00, top_digit};
                last_next    = (dig_cnt_reg == sidec_pkg::DIG_CNT_W'(1));
                bcd_next     = {bcd_reg[sidec_pkg::BCD_W-5:0], 4'd0};
                dig_cnt_next = dig_cnt_reg - 1'b1;
                if (dig_cnt_reg == sidec_pkg::DIG_CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mag_reg      <= '0;
            bcd_reg      <= '0;
            neg_reg      <= 1'b0;
            conv_cnt_reg <= '0;
            dig_cnt_reg  <= '0;
            strobe_reg   <= 1'b0;
            char_reg     <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mag_reg      <= mag_next;
            bcd_reg      <= bcd_next;
            neg_reg      <= neg_next;
            conv_cnt_reg <= conv_cnt_next;
            dig_cnt_reg  <= dig_cnt_next;
            strobe_reg   <= strobe_next;
            char_reg     <= char_next;
            last_reg     <= last_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign ascii_char = char_reg;
    assign last_char  = last_reg;

    // A word that is not the last one is always followed by more of the same number.
    `ASSERT_NOW(a_more_chars_busy, strobe && !last_char, busy, "character stream cut short")
    // The last word of a number is never directly followed by another word.
    `ASSERT_NEXT(a_gap_after_last, strobe && last_char, !strobe, "word right after last")
    // A newly taken number starts its conversion with no word on the output.
    `ASSERT_NEXT(a_start_quiet, start && !busy, busy && !strobe, "word too early after start")
    // Only a minus sign or a decimal digit is ever emitted.
    `ASSERT_NOW(a_char_code, strobe,
        ascii_char == sidec_pkg::CHAR_MINUS ||
        (ascii_char >= sidec_pkg::CHAR_ZERO && ascii_char <= sidec_pkg::CHAR_ZERO + 6'd9),
        "illegal character code")

endmodule

/* dv/signed_int_to_decimal_ascii_tb.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Feeds signed integers to the converter: a directed set of edge values first,
// then random values of every size. Each accepted word is predicted as its
// decimal text and checked character by character against the strobed output.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic signed [sidec_pkg::NUM_WIDTH-1:0] value;
        int unsigned                            gap_pct;
    } number_item_t;

    typedef struct {
        logic [sidec_pkg::CHAR_W-1:0] ch;
        logic                         last;
    } text_char_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   start = 1'b0;
    logic                                   busy;
    logic signed [sidec_pkg::NUM_WIDTH-1:0] number = '0;
    logic                                   strobe;
    logic [sidec_pkg::CHAR_W-1:0]           ascii_char;
    logic                                   last_char;

    number_item_t number_q[$];
    text_char_t   text_q[$];
    int           error_count = 0;
    int           stall_cycles = 0;

    signed_int_to_decimal_ascii dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .number     (number),
        .strobe     (strobe),
        .ascii_char (ascii_char),
        .last_char  (last_char)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Appends the expected decimal text of one word, sign first.
    task automatic predict_text(input logic [sidec_pkg::NUM_WIDTH-1:0] value);
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] mag;
        bit          negative;
        int          digits[24];
        int          nd;
        text_char_t  c;
        begin
            mask = (64'd1 << sidec_pkg::INT_WIDTH) - 64'd1;
            v = 64'(value) & mask;
            negative = v[sidec_pkg::INT_WIDTH-1];
            // Taking the magnitude unsigned keeps the most negative value exact.
            mag = negative ? ((~v + 64'd1) & mask) : v;
            nd = 0;
            do
            begin
                digits[nd] = int'(mag % 64'd10);
                nd++;
                mag = mag / 64'd10;
            end
            while (mag != 64'd0);
            if (negative)
            begin
                c.ch = sidec_pkg::CHAR_MINUS;
                c.last = 1'b0;
                text_q.push_back(c);
            end
            for (int k = nd - 1; k >= 0; k--)
            begin
                c.ch = sidec_pkg::CHAR_ZERO + sidec_pkg::CHAR_W'(digits[k]);
                c.last = (k == 0);
                text_q.push_back(c);
            end
        end
    endtask

    function automatic logic signed [sidec_pkg::NUM_WIDTH-1:0] random_number();
        logic signed [sidec_pkg::NUM_WIDTH-1:0] v;
        int unsigned                            d;
        int unsigned                            limit;
        begin
            case ($urandom_range(3))
                0: v = $urandom;
                1: v = $urandom_range(99);
                2:
                begin
                    d = $urandom_range(1, 9);
                    limit = 1;
                    repeat (d) limit = limit * 10;
                    v = $urandom_range(limit - 1);
                end
                default:
                begin
                    if ($urandom_range(1))
                        v = 32'sh7FFF_FFFF - $urandom_range(20);
                    else
                        v = 32'sh8000_0000 + $urandom_range(20);
                end
            endcase
            if ($urandom_range(1) && v != 32'sh8000_0000)
                v = -v;
            return v;
        end
    endfunction

    task automatic add_number(input logic signed [sidec_pkg::NUM_WIDTH-1:0] value,
                              input int unsigned gap_pct);
        number_item_t item;
        begin
            item.value = value;
            item.gap_pct = gap_pct;
            number_q.push_back(item);
        end
    endtask

    // Driver: a word is taken when start is high and busy is low at the edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            number <= '0;
        end
        else
        begin
            if (start && !busy)
                predict_text(number);
            if (!start || !busy)
            begin
                if (number_q.size() != 0 && $urandom_range(99) >= number_q[0].gap_pct)
                begin
                    start <= 1'b1;
                    number <= number_q.pop_front().value;
                end
                else
                begin
                    start <= 1'b0;
                    number <= $urandom;
                end
            end
        end
    end

    // Monitor: every strobed character must match the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (text_q.size() == 0)
            begin
                $error("unexpected character: ascii_char=%0d last_char=%0b",
                       ascii_char, last_char);
                error_count++;
            end
            else
            begin
                text_char_t exp_c;
                exp_c = text_q.pop_front();
                if (ascii_char !== exp_c.ch)
                begin
                    $error("ascii_char: expected %0d, got %0d", exp_c.ch, ascii_char);
                    error_count++;
                end
                if (last_char !== exp_c.last)
                begin
                    $error("last_char: expected %0b, got %0b", exp_c.last, last_char);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [sidec_pkg::NUM_WIDTH-1:0] directed[$];
        directed = '{0, 1, -1, 7, -9, 9, 10, -10, 99, 100, -100,
                     32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001,
                     1000000000, -1000000000, 999999999, -999999999,
                     123456789, -987654321, 32'sh5555_5555, 32'shAAAA_AAAA};
        foreach (directed[i])
            add_number(directed[i], 31);
        repeat (75) add_number(random_number(), 31);
        repeat (75) add_number(random_number(), 77);
        repeat (58) add_number(random_number(), 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (number_q.size() != 0 || start || text_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && text_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/sidec_pkg.sv
sv/signed_int_to_decimal_ascii.sv
dv/signed_int_to_decimal_ascii_tb.sv
